FILE: rtl/mdht_pkg.sv
// ----------------------------------------------------------------------------
// mdht_pkg
// Types and constants shared by the minimum-distance hazard tracker.
// ----------------------------------------------------------------------------
package mdht_pkg;

  localparam int unsigned KEY_W  = 52;
  localparam int unsigned INFO_W = 48;

  // Result status codes
  localparam logic [1:0] STATUS_NO_GAP = 2'd0;
  localparam logic [1:0] STATUS_GAP    = 2'd1;
  localparam logic [1:0] STATUS_ORDER  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef struct packed {
    logic        is_min_distance;
    logic [3:0]  ref_kind;
    logic [15:0] ref_id;
    logic [15:0] src_stage;
    logic [15:0] dst_stage;
    logic [15:0] bb_index;
    logic [31:0] node_id;
    logic [31:0] sched_pos;
    logic [31:0] issue_cyc;
    logic [15:0] hz_ord;
    logic [15:0] min_gap;
    logic [15:0] flag_bits;
  } hazard_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] prod_node;
    logic [31:0] producer_order;
    logic [31:0] producer_cycle;
    logic [15:0] producer_hazard_index;
    logic [15:0] required_gap;
    logic [31:0] actual_gap;
    logic [15:0] delay_needed;
    logic [15:0] merged_flags;
  } result_t;

  // One producer record as held in the table RAM
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [31:0]       node;
    logic [31:0]       order;
    logic [31:0]       cycle;
    logic [INFO_W-1:0] info;   // hazard ordinal, distance, flags
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_WRITE,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic take;      // open the input port
    logic scan;      // step the table scan
    logic resolve;   // evaluate the gap and register the result
    logic write;     // commit the record update
    logic emit;      // hand the result to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic in_fire;   // input transaction this cycle
    logic use_min;   // incoming use is a minimum-distance use
    logic scan_done; // every valid record has been compared
    logic out_free;  // output register can take a result
  } dp_status_t;

  function automatic logic [KEY_W-1:0] make_key(
    input logic [3:0]  rkind,
    input logic [15:0] rid,
    input logic [15:0] stage,
    input logic [15:0] block
  );
    return {rkind, rid, stage, block};
  endfunction

endpackage

FILE: rtl/mdht_hazard_if.sv
// ----------------------------------------------------------------------------
// mdht_hazard_if
// Valid/ready channel carrying one hazard use.
// ----------------------------------------------------------------------------
interface mdht_hazard_if;
  import mdht_pkg::*;

  logic    valid;
  logic    ready;
  hazard_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mdht_result_if.sv
// ----------------------------------------------------------------------------
// mdht_result_if
// Valid/ready channel carrying one tracker result.
// ----------------------------------------------------------------------------
interface mdht_result_if;
  import mdht_pkg::*;

  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/mdht_ram.sv
// ----------------------------------------------------------------------------
// mdht_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mdht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mdht_ctrl.sv
// ----------------------------------------------------------------------------
// mdht_ctrl
// Sequencer: take a use, scan the table, resolve, commit, emit (ignored uses skip to emit).
// ----------------------------------------------------------------------------
module mdht_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  mdht_pkg::dp_status_t sts,
  output mdht_pkg::dp_cmd_t    cmd
);
  import mdht_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_fire) begin
          // ignored uses skip straight to the output with a cleared result
          state_next = sts.use_min ? ST_SCAN : ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        cmd.resolve = 1'b1;
        state_next  = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/mdht_dp.sv
// ----------------------------------------------------------------------------
// mdht_dp
// Datapath: item register, record table, scan compare, gap arithmetic,
// output register.
// ----------------------------------------------------------------------------
module mdht_dp #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  mdht_pkg::dp_cmd_t cmd,
  output mdht_pkg::dp_status_t sts,
  mdht_hazard_if.sink       hazard,
  mdht_result_if.source     result
);
  import mdht_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic              in_fire;
  hazard_t           item;
  logic [KEY_W-1:0]  look_key;
  logic [KEY_W-1:0]  upd_key;

  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic              issue;
  logic              cmp_valid;
  logic [AW-1:0]     cmp_idx;
  entry_t            rd_entry;
  logic [$bits(entry_t)-1:0] rd_raw;

  logic              hit_found;
  logic [31:0]       hit_node;
  logic [31:0]       hit_order;
  logic [31:0]       hit_cycle;
  logic [INFO_W-1:0] hit_info;
  logic              upd_found;
  logic [AW-1:0]     upd_idx;

  logic [32:0]       diff;
  logic              borrow;
  logic [15:0]       pdist;
  logic [15:0]       req;
  logic              order_err;
  logic              short_gap;
  logic              full;

  result_t           res;
  logic              do_write;
  logic              out_valid;
  result_t           out_data;

  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wentry;

  // Input side: keep the port closed while in reset
  assign hazard.ready = cmd.take & ~rst;
  assign in_fire      = hazard.valid & cmd.take & ~rst;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= hazard.payload;
    end
  end

  assign look_key = make_key(item.ref_kind, item.ref_id,
                             item.dst_stage, item.bb_index);
  assign upd_key  = make_key(item.ref_kind, item.ref_id,
                             item.src_stage, item.bb_index);

  // Table scan: one read issued per cycle, compared in the cycle after its issue
  assign issue    = cmd.scan && (rd_ptr < count);
  assign rd_entry = entry_t'(rd_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      hit_found <= 1'b0;
      upd_found <= 1'b0;
    end else if (in_fire) begin
      rd_ptr    <= '0;
      cmp_valid <= 1'b0;
      hit_found <= 1'b0;
      upd_found <= 1'b0;
    end else if (cmd.scan) begin
      cmp_valid <= issue;
      if (issue) begin
        rd_ptr  <= rd_ptr + CW'(1);
      end
      if (cmp_valid && !hit_found && rd_entry.key == look_key) begin
        hit_found <= 1'b1;
      end
      if (cmp_valid && !upd_found && rd_entry.key == upd_key) begin
        upd_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      cmp_idx <= rd_ptr[AW-1:0];
    end
    if (cmd.scan && cmp_valid && !hit_found && rd_entry.key == look_key) begin
      hit_node  <= rd_entry.node;
      hit_order <= rd_entry.order;
      hit_cycle <= rd_entry.cycle;
      hit_info  <= rd_entry.info;
    end
    if (cmd.scan && cmp_valid && !upd_found && rd_entry.key == upd_key) begin
      upd_idx <= cmp_idx;
    end
  end

  // Gap evaluation
  assign diff      = {1'b0, item.issue_cyc} - {1'b0, hit_cycle};
  assign borrow    = diff[32];
  assign pdist     = hit_info[31:16];
  assign req       = (pdist > item.min_gap) ? pdist : item.min_gap;
  assign order_err = hit_found && borrow;
  assign short_gap = hit_found && !borrow && (diff[31:16] == 16'd0) &&
                     (diff[15:0] < req);
  assign full      = !upd_found && (count >= CW'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res      <= '0;
      do_write <= 1'b0;
    end else if (cmd.resolve) begin
      res <= '0;
      if (hit_found) begin
        res.prod_node             <= hit_node;
        res.producer_order        <= hit_order;
        res.producer_cycle        <= hit_cycle;
        res.producer_hazard_index <= hit_info[47:32];
        res.required_gap          <= req;
        res.merged_flags          <= hit_info[15:0] | item.flag_bits;
        if (!borrow) begin
          res.actual_gap <= diff[31:0];
        end
        if (short_gap) begin
          res.delay_needed <= req - diff[15:0];
        end
      end
      if (order_err) begin
        res.status <= STATUS_ORDER;
      end else if (full) begin
        res.status <= STATUS_FULL;
      end else if (short_gap) begin
        res.status <= STATUS_GAP;
      end else begin
        res.status <= STATUS_NO_GAP;
      end
      do_write <= !order_err && !full;
    end
  end

  // Record update or append
  assign we    = cmd.write && do_write;
  assign waddr = upd_found ? upd_idx : count[AW-1:0];

  always_comb begin
    wentry       = '0;
    wentry.key   = upd_key;
    wentry.node  = item.node_id;
    wentry.order = item.sched_pos;
    wentry.cycle = item.issue_cyc;
    wentry.info  = {item.hz_ord, item.min_gap, item.flag_bits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (we && !upd_found) begin
      count <= count + CW'(1);
    end
  end

  mdht_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rd_raw)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && sts.out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && sts.out_free) begin
      out_data <= res;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  always_comb begin
    sts.in_fire   = in_fire;
    sts.use_min   = hazard.payload.is_min_distance;
    sts.scan_done = !issue && !cmp_valid && (rd_ptr >= count);
    sts.out_free  = !out_valid || result.ready;
  end

endmodule

FILE: rtl/min_distance_hazard_tracker.sv
// ----------------------------------------------------------------------------
// min_distance_hazard_tracker
// Tracks producer records of minimum-distance hazards and checks each new
// minimum-distance use against the latest recorded matching producer.
// ----------------------------------------------------------------------------
//
//   channel   dir   carries                          transaction
//   -------   ---   ------------------------------   ---------------------------
//   hazard    in    one hazard use (hazard_t)        valid & ready at clk edge
//   result    out   one status record (result_t)     valid & ready at clk edge
//
// An ignored use goes from IDLE straight to EMIT and is registered at the output,
// with a cleared result, once the output register is free; the input then reopens.
// A minimum-distance use compares the N valid records one per cycle in SCAN (single
// RAM read port, lookup and update keys together), then passes RESOLVE, WRITE, EMIT.
// Reset (rst, synchronous) closes the input and empties the table by clearing
// the fill count; no RAM sweep is run, only filled slots are ever compared.
// A stalled result sits in the output register; the next use is taken
// meanwhile and waits only at its own hand-over if the register is still full.
// ----------------------------------------------------------------------------
module min_distance_hazard_tracker #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  mdht_hazard_if.sink   hazard,
  mdht_result_if.source result
);
  import mdht_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // Sequencer: owns the per-use phases
  mdht_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Datapath: record table, compare, gap arithmetic and output register
  mdht_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .hazard (hazard),
    .result (result)
  );

endmodule
